FILE: hw/rtl/direct_mapped_unit_cache_assert.svh
// Assertion macros used by the cache top level.
`ifndef DIRECT_MAPPED_UNIT_CACHE_ASSERT_SVH
`define DIRECT_MAPPED_UNIT_CACHE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DMUC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cache assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DMUC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cache assertion failed");

`endif

FILE: hw/rtl/dmuc_pkg.sv
// Package with sizes, codes and control types of the direct-mapped unit cache.
`timescale 1ns / 1ps
package dmuc_pkg;
  localparam int LINE_UNITS = 16;
  localparam int LINE_COUNT = 16;
  localparam int UNIT_BITS = 32;
  localparam int INDEX_BITS = 24;

  localparam int WORD_BITS = $clog2(LINE_UNITS);
  localparam int SLOT_BITS = $clog2(LINE_COUNT);
  localparam int LNUM_BITS = INDEX_BITS - WORD_BITS;
  localparam int ADDR_BITS = SLOT_BITS + WORD_BITS;
  localparam int MEM_DEPTH = LINE_COUNT * LINE_UNITS;

  localparam logic [UNIT_BITS-1:0] MARKER = {(UNIT_BITS / 8){8'h0A}};

  localparam logic [1:0] OP_SET = 2'd0;
  localparam logic [1:0] OP_GET = 2'd1;
  localparam logic [1:0] OP_FILL = 2'd2;

  localparam logic [1:0] KIND_REPLY = 2'd0;
  localparam logic [1:0] KIND_WB = 2'd1;
  localparam logic [1:0] KIND_FILL = 2'd2;

  typedef struct packed {
    logic accept_req;
    logic accept_fill;
    logic rd_pend;
    logic lookup;
    logic wb_first;
    logic wb_emit;
    logic fill_req;
  } dmuc_cmd_t;

  typedef struct packed {
    logic awaiting;
    logic fill_last;
    logic hit;
    logic victim_valid;
    logic wb_last;
  } dmuc_sts_t;
endpackage

FILE: hw/rtl/dmuc_ctrl.sv
// Controller state machine that sequences lookups, write-backs and fills.
`timescale 1ns / 1ps
module dmuc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [1:0]          in_op,
  input  dmuc_pkg::dmuc_sts_t sts,
  output dmuc_pkg::dmuc_cmd_t cmd,
  output logic                busy
);
  import dmuc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_WB,
    S_FILL_REQ,
    S_FILL_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if ((in_op == OP_SET || in_op == OP_GET) && !sts.awaiting) begin
            cmd.accept_req = 1'b1;
            state_nxt = S_LOOKUP;
          end else if (in_op == OP_FILL && sts.awaiting) begin
            cmd.accept_fill = 1'b1;
            if (sts.fill_last) begin
              state_nxt = S_FILL_DONE;
            end
          end
        end
      end
      S_LOOKUP: begin
        if (sts.hit) begin
          cmd.lookup = 1'b1;
          state_nxt = S_IDLE;
        end else if (sts.victim_valid) begin
          cmd.wb_first = 1'b1;
          state_nxt = S_WB;
        end else begin
          state_nxt = S_FILL_REQ;
        end
      end
      S_WB: begin
        cmd.wb_emit = 1'b1;
        if (sts.wb_last) begin
          state_nxt = S_FILL_REQ;
        end
      end
      S_FILL_REQ: begin
        cmd.fill_req = 1'b1;
        state_nxt = S_IDLE;
      end
      S_FILL_DONE: begin
        cmd.rd_pend = 1'b1;
        state_nxt = S_LOOKUP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
endmodule

FILE: hw/rtl/dmuc_datapath.sv
// Datapath with line memory, tags, valid bits, request and result registers.
`timescale 1ns / 1ps
module dmuc_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  dmuc_pkg::dmuc_cmd_t                  cmd,
  output dmuc_pkg::dmuc_sts_t                  sts,
  input  logic [1:0]                           in_op,
  input  logic [dmuc_pkg::INDEX_BITS-1:0]      in_unit_index,
  input  logic [dmuc_pkg::UNIT_BITS-1:0]       in_write_value,
  input  logic [dmuc_pkg::UNIT_BITS-1:0]       in_fill_data,
  input  logic                                 in_fill_present,
  output logic                                 out_valid,
  output logic [1:0]                           out_kind,
  output logic                                 out_status,
  output logic [dmuc_pkg::UNIT_BITS-1:0]       out_read_value,
  output logic [dmuc_pkg::INDEX_BITS-1:0]      out_backing_index,
  output logic [dmuc_pkg::UNIT_BITS-1:0]       out_backing_data,
  output logic                                 out_last
);
  import dmuc_pkg::*;

  logic [UNIT_BITS-1:0] mem [MEM_DEPTH];
  logic [UNIT_BITS-1:0] rdata_r;
  logic [LNUM_BITS-1:0] lnum_r [LINE_COUNT];
  logic [LINE_COUNT-1:0] valid_r;

  logic [1:0] req_op_r;
  logic [INDEX_BITS-1:0] req_index_r;
  logic [UNIT_BITS-1:0] req_value_r;
  logic awaiting_r;
  logic [WORD_BITS-1:0] fill_cnt_r;
  logic [WORD_BITS-1:0] wb_cnt_r;

  logic out_valid_r;
  logic [1:0] out_kind_r;
  logic out_status_r;
  logic [UNIT_BITS-1:0] out_read_value_r;
  logic [INDEX_BITS-1:0] out_backing_index_r;
  logic [UNIT_BITS-1:0] out_backing_data_r;
  logic out_last_r;

  logic [LNUM_BITS-1:0] req_ln;
  logic [SLOT_BITS-1:0] req_slot;
  logic [WORD_BITS-1:0] req_word;
  logic [ADDR_BITS-1:0] raddr;
  logic [ADDR_BITS-1:0] waddr;
  logic [UNIT_BITS-1:0] wdata;
  logic we;
  logic is_marker;

  assign req_ln = req_index_r[INDEX_BITS-1:WORD_BITS];
  assign req_slot = req_ln[SLOT_BITS-1:0];
  assign req_word = req_index_r[WORD_BITS-1:0];
  assign is_marker = (rdata_r == MARKER);

  always_comb begin
    priority if (cmd.accept_req) begin
      raddr = {in_unit_index[WORD_BITS+SLOT_BITS-1:WORD_BITS],
               in_unit_index[WORD_BITS-1:0]};
    end else if (cmd.wb_first) begin
      raddr = {req_slot, {WORD_BITS{1'b0}}};
    end else if (cmd.wb_emit) begin
      raddr = {req_slot, wb_cnt_r + WORD_BITS'(1)};
    end else if (cmd.rd_pend) begin
      raddr = {req_slot, req_word};
    end else begin
      raddr = {req_slot, req_word};
    end
  end

  always_comb begin
    we = cmd.accept_fill || (cmd.lookup && req_op_r == OP_SET);
    if (cmd.accept_fill) begin
      waddr = {req_slot, fill_cnt_r};
      wdata = in_fill_present ? in_fill_data : MARKER;
    end else begin
      waddr = {req_slot, req_word};
      wdata = req_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_req) begin
      req_op_r <= in_op;
      req_index_r <= in_unit_index;
      req_value_r <= in_write_value;
    end
    if (cmd.accept_fill && fill_cnt_r == WORD_BITS'(LINE_UNITS - 1)) begin
      lnum_r[req_slot] <= req_ln;
    end
    if (cmd.wb_first) begin
      wb_cnt_r <= '0;
    end else if (cmd.wb_emit) begin
      wb_cnt_r <= wb_cnt_r + WORD_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      awaiting_r <= 1'b0;
      fill_cnt_r <= '0;
    end else begin
      if (cmd.accept_fill) begin
        fill_cnt_r <= fill_cnt_r + WORD_BITS'(1);
        if (fill_cnt_r == WORD_BITS'(LINE_UNITS - 1)) begin
          valid_r[req_slot] <= 1'b1;
          awaiting_r <= 1'b0;
        end
      end
      if (cmd.wb_emit && wb_cnt_r == WORD_BITS'(LINE_UNITS - 1)) begin
        valid_r[req_slot] <= 1'b0;
      end
      if (cmd.fill_req) begin
        awaiting_r <= 1'b1;
        fill_cnt_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.lookup || cmd.wb_emit || cmd.fill_req;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      out_kind_r <= KIND_REPLY;
      out_status_r <= (req_op_r == OP_GET) && is_marker;
      out_read_value_r <= ((req_op_r == OP_GET) && !is_marker) ? rdata_r : '0;
      out_backing_index_r <= '0;
      out_backing_data_r <= '0;
      out_last_r <= 1'b1;
    end else if (cmd.wb_emit) begin
      out_kind_r <= KIND_WB;
      out_status_r <= 1'b0;
      out_read_value_r <= '0;
      out_backing_index_r <= {lnum_r[req_slot], wb_cnt_r};
      out_backing_data_r <= rdata_r;
      out_last_r <= 1'b0;
    end else if (cmd.fill_req) begin
      out_kind_r <= KIND_FILL;
      out_status_r <= 1'b0;
      out_read_value_r <= '0;
      out_backing_index_r <= {req_ln, {WORD_BITS{1'b0}}};
      out_backing_data_r <= '0;
      out_last_r <= 1'b1;
    end
  end

  assign sts.awaiting = awaiting_r;
  assign sts.fill_last = (fill_cnt_r == WORD_BITS'(LINE_UNITS - 1));
  assign sts.hit = valid_r[req_slot] && (lnum_r[req_slot] == req_ln);
  assign sts.victim_valid = valid_r[req_slot];
  assign sts.wb_last = (wb_cnt_r == WORD_BITS'(LINE_UNITS - 1));

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_status = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_backing_index = out_backing_index_r;
  assign out_backing_data = out_backing_data_r;
  assign out_last = out_last_r;
endmodule

FILE: hw/rtl/direct_mapped_unit_cache.sv
// Top level of the direct-mapped unit cache: controller, datapath and checks.
// A hit is busy in the lookup state and strobes its reply in the next cycle.
// A miss is busy for the lookup, a write-back of each unit if the victim line is valid and
// for the fill request, each result strobed in the cycle after; fill items are taken without
// going busy, but the last one leads through the fill-done and lookup states to the reply.
// Synchronous reset clears valid bits, fill state and the result strobe; results cannot stall.
`timescale 1ns / 1ps
`include "direct_mapped_unit_cache_assert.svh"
module direct_mapped_unit_cache (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_op,
  input  logic [dmuc_pkg::INDEX_BITS-1:0] in_unit_index,
  input  logic [dmuc_pkg::UNIT_BITS-1:0]  in_write_value,
  input  logic [dmuc_pkg::UNIT_BITS-1:0]  in_fill_data,
  input  logic                            in_fill_present,
  output logic                            out_valid,
  output logic [1:0]                      out_kind,
  output logic                            out_status,
  output logic [dmuc_pkg::UNIT_BITS-1:0]  out_read_value,
  output logic [dmuc_pkg::INDEX_BITS-1:0] out_backing_index,
  output logic [dmuc_pkg::UNIT_BITS-1:0]  out_backing_data,
  output logic                            out_last
);
  import dmuc_pkg::*;

  dmuc_cmd_t cmd;
  dmuc_sts_t sts;

  dmuc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dmuc_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_op             (in_op),
    .in_unit_index     (in_unit_index),
    .in_write_value    (in_write_value),
    .in_fill_data      (in_fill_data),
    .in_fill_present   (in_fill_present),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_read_value    (out_read_value),
    .out_backing_index (out_backing_index),
    .out_backing_data  (out_backing_data),
    .out_last          (out_last)
  );

  `DMUC_ASSERT_NEXT(a_no_result_after_accept, start && !busy, !out_valid)
  `DMUC_ASSERT_NOW(a_wb_keeps_busy, out_valid && out_kind == KIND_WB, busy)
  `DMUC_ASSERT_NOW(a_fill_req_awaits, out_valid && out_kind == KIND_FILL, sts.awaiting)
  `DMUC_ASSERT_NOW(a_reply_is_last, out_valid && out_kind == KIND_REPLY, out_last && !busy)
endmodule

FILE: test/direct_mapped_unit_cache_checker.sv
// Checker for the direct-mapped unit cache: predicts every result and compares it.
`timescale 1ns / 1ps
module direct_mapped_unit_cache_checker
  import dmuc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [INDEX_BITS-1:0] in_unit_index,
  input  logic [UNIT_BITS-1:0]  in_write_value,
  input  logic [UNIT_BITS-1:0]  in_fill_data,
  input  logic                  in_fill_present,
  input  logic                  out_valid,
  input  logic [1:0]            out_kind,
  input  logic                  out_status,
  input  logic [UNIT_BITS-1:0]  out_read_value,
  input  logic [INDEX_BITS-1:0] out_backing_index,
  input  logic [UNIT_BITS-1:0]  out_backing_data,
  input  logic                  out_last,
  output int                    fail_count,
  output int                    results_due,
  output int                    hit_count,
  output int                    miss_count,
  output int                    writeback_count,
  output int                    unset_count,
  output int                    ignored_count
);

  typedef struct packed {
    logic [1:0]            kind;
    logic                  status;
    logic [UNIT_BITS-1:0]  read_value;
    logic [INDEX_BITS-1:0] backing_index;
    logic [UNIT_BITS-1:0]  backing_data;
    logic                  last;
  } cache_result_t;

  cache_result_t expected_q[$];
  cache_result_t seen;

  logic [UNIT_BITS-1:0]  store_words [MEM_DEPTH];
  logic [LNUM_BITS-1:0]  line_tag [LINE_COUNT];
  bit                    line_ok [LINE_COUNT];
  logic [1:0]            pend_op;
  logic [INDEX_BITS-1:0] pend_idx;
  logic [UNIT_BITS-1:0]  pend_val;
  int                    fill_cnt;
  bit                    awaiting;

  int errors;
  int hits;
  int misses;
  int wb_words;
  int unset_reads;
  int ignored;

  function automatic void push_result(logic [1:0] k, logic st, logic [UNIT_BITS-1:0] rv,
                                      logic [INDEX_BITS-1:0] bi, logic [UNIT_BITS-1:0] bd,
                                      logic lst);
    cache_result_t r;
    r.kind = k;
    r.status = st;
    r.read_value = rv;
    r.backing_index = bi;
    r.backing_data = bd;
    r.last = lst;
    expected_q.push_back(r);
  endfunction

  function automatic void complete_request(logic [1:0] op, logic [INDEX_BITS-1:0] idx,
                                           logic [UNIT_BITS-1:0] wv);
    logic [ADDR_BITS-1:0] addr;
    addr = {idx[WORD_BITS +: SLOT_BITS], idx[WORD_BITS-1:0]};
    if (op == OP_SET) begin
      store_words[addr] = wv;
      push_result(KIND_REPLY, 1'b0, '0, '0, '0, 1'b1);
    end else if (store_words[addr] == MARKER) begin
      unset_reads++;
      push_result(KIND_REPLY, 1'b1, '0, '0, '0, 1'b1);
    end else begin
      push_result(KIND_REPLY, 1'b0, store_words[addr], '0, '0, 1'b1);
    end
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [INDEX_BITS-1:0] idx,
                                       logic [UNIT_BITS-1:0] wv, logic [UNIT_BITS-1:0] fd,
                                       logic fp);
    logic [LNUM_BITS-1:0] lnum;
    logic [SLOT_BITS-1:0] slot;
    logic [WORD_BITS-1:0] wsel;
    case (op)
      OP_SET, OP_GET: begin
        if (awaiting) begin
          ignored++;
        end else begin
          lnum = idx[INDEX_BITS-1:WORD_BITS];
          slot = lnum[SLOT_BITS-1:0];
          if (line_ok[slot] && line_tag[slot] == lnum) begin
            hits++;
            complete_request(op, idx, wv);
          end else begin
            misses++;
            if (line_ok[slot]) begin
              for (int w = 0; w < LINE_UNITS; w++) begin
                wsel = w[WORD_BITS-1:0];
                push_result(KIND_WB, 1'b0, '0, {line_tag[slot], wsel},
                            store_words[{slot, wsel}], 1'b0);
                wb_words++;
              end
              line_ok[slot] = 1'b0;
            end
            push_result(KIND_FILL, 1'b0, '0, {lnum, {WORD_BITS{1'b0}}}, '0, 1'b1);
            pend_op = op;
            pend_idx = idx;
            pend_val = wv;
            fill_cnt = 0;
            awaiting = 1'b1;
          end
        end
      end
      OP_FILL: begin
        if (!awaiting) begin
          ignored++;
        end else begin
          slot = pend_idx[WORD_BITS +: SLOT_BITS];
          wsel = fill_cnt[WORD_BITS-1:0];
          store_words[{slot, wsel}] = fp ? fd : MARKER;
          fill_cnt++;
          if (fill_cnt == LINE_UNITS) begin
            line_ok[slot] = 1'b1;
            line_tag[slot] = pend_idx[INDEX_BITS-1:WORD_BITS];
            awaiting = 1'b0;
            fill_cnt = 0;
            complete_request(pend_op, pend_idx, pend_val);
          end
        end
      end
      default: ignored++;
    endcase
  endfunction

  function automatic bit field_differs(string name, logic [UNIT_BITS-1:0] want,
                                       logic [UNIT_BITS-1:0] got);
    if (want === got) return 1'b0;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    return 1'b1;
  endfunction

  function automatic void compare_result(cache_result_t want, cache_result_t got);
    bit bad;
    bad = field_differs("kind", UNIT_BITS'(want.kind), UNIT_BITS'(got.kind))
        | field_differs("status", UNIT_BITS'(want.status), UNIT_BITS'(got.status))
        | field_differs("read_value", want.read_value, got.read_value)
        | field_differs("backing_index", UNIT_BITS'(want.backing_index),
                        UNIT_BITS'(got.backing_index))
        | field_differs("backing_data", want.backing_data, got.backing_data)
        | field_differs("last", UNIT_BITS'(want.last), UNIT_BITS'(got.last));
    if (bad) errors++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < LINE_COUNT; s++) line_ok[s] = 1'b0;
      expected_q.delete();
      pend_op = OP_SET;
      pend_idx = '0;
      pend_val = '0;
      fill_cnt = 0;
      awaiting = 1'b0;
    end else begin
      if (out_valid) begin
        seen.kind = out_kind;
        seen.status = out_status;
        seen.read_value = out_read_value;
        seen.backing_index = out_backing_index;
        seen.backing_data = out_backing_data;
        seen.last = out_last;
        if (expected_q.size() == 0) begin
          $display("%0t: result of kind %0d, index %h arrived with none expected",
                   $time, out_kind, out_backing_index);
          errors++;
        end else begin
          compare_result(expected_q.pop_front(), seen);
        end
      end
      if (start && !busy)
        predict_item(in_op, in_unit_index, in_write_value, in_fill_data, in_fill_present);
    end
    fail_count <= errors;
    results_due <= expected_q.size();
    hit_count <= hits;
    miss_count <= misses;
    writeback_count <= wb_words;
    unset_count <= unset_reads;
    ignored_count <= ignored;
  end

endmodule

FILE: test/direct_mapped_unit_cache_tb.sv
// Testbench top for the direct-mapped unit cache: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module direct_mapped_unit_cache_tb;
  import dmuc_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 200;
  localparam int POOL_SIZE = 20;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [1:0]            in_op;
  logic [INDEX_BITS-1:0] in_unit_index;
  logic [UNIT_BITS-1:0]  in_write_value;
  logic [UNIT_BITS-1:0]  in_fill_data;
  logic                  in_fill_present;
  logic                  out_valid;
  logic [1:0]            out_kind;
  logic                  out_status;
  logic [UNIT_BITS-1:0]  out_read_value;
  logic [INDEX_BITS-1:0] out_backing_index;
  logic [UNIT_BITS-1:0]  out_backing_data;
  logic                  out_last;

  int fail_count;
  int results_due;
  int hit_count;
  int miss_count;
  int writeback_count;
  int unset_count;
  int ignored_count;

  int                   items_sent;
  int                   fills_left;
  bit                   awaiting_line;
  bit                   gaps_on;
  int                   idle_cycles;
  logic [LNUM_BITS-1:0] line_pool [POOL_SIZE];

  always #4 clk = ~clk;

  direct_mapped_unit_cache DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_unit_index(in_unit_index),
    .in_write_value(in_write_value),
    .in_fill_data(in_fill_data),
    .in_fill_present(in_fill_present),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_backing_index(out_backing_index),
    .out_backing_data(out_backing_data),
    .out_last(out_last)
  );

  direct_mapped_unit_cache_checker CHK (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_op(in_op),
    .in_unit_index(in_unit_index),
    .in_write_value(in_write_value),
    .in_fill_data(in_fill_data),
    .in_fill_present(in_fill_present),
    .out_valid(out_valid),
    .out_kind(out_kind),
    .out_status(out_status),
    .out_read_value(out_read_value),
    .out_backing_index(out_backing_index),
    .out_backing_data(out_backing_data),
    .out_last(out_last),
    .fail_count(fail_count),
    .results_due(results_due),
    .hit_count(hit_count),
    .miss_count(miss_count),
    .writeback_count(writeback_count),
    .unset_count(unset_count),
    .ignored_count(ignored_count)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [UNIT_BITS-1:0] pick_unit();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return MARKER;
    return $urandom;
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_unit_index();
    logic [WORD_BITS-1:0] w;
    if ($urandom_range(9) == 0) return INDEX_BITS'($urandom);
    w = WORD_BITS'($urandom_range(LINE_UNITS - 1));
    return {line_pool[$urandom_range(POOL_SIZE - 1)], w};
  endfunction

  task automatic drive_item(logic [1:0] op, logic [INDEX_BITS-1:0] idx,
                            logic [UNIT_BITS-1:0] wv, logic [UNIT_BITS-1:0] fd, logic fp);
    if (gaps_on) begin
      while ($urandom_range(99) < 9) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    in_op <= op;
    in_unit_index <= idx;
    in_write_value <= wv;
    in_fill_data <= fd;
    in_fill_present <= fp;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  task automatic await_outcome(output logic [1:0] k);
    start <= 1'b0;
    do @(posedge clk); while (!(out_valid === 1'b1 && out_last === 1'b1));
    k = out_kind;
  endtask

  task automatic run_request(logic [1:0] op, logic [INDEX_BITS-1:0] idx,
                             logic [UNIT_BITS-1:0] wv);
    logic [1:0] k;
    drive_item(op, idx, wv, $urandom, 1'($urandom_range(1)));
    items_sent++;
    await_outcome(k);
    if (k == KIND_FILL) begin
      awaiting_line = 1'b1;
      fills_left = LINE_UNITS;
    end
  endtask

  task automatic send_fill(logic [UNIT_BITS-1:0] fd, logic fp);
    logic [1:0] k;
    drive_item(OP_FILL, INDEX_BITS'($urandom), $urandom, fd, fp);
    items_sent++;
    fills_left--;
    if (fills_left == 0) begin
      await_outcome(k);
      awaiting_line = 1'b0;
    end
  endtask

  initial begin
    int random_base;
    int r;
    items_sent = 0;
    fills_left = 0;
    awaiting_line = 1'b0;
    gaps_on = 1'b1;
    for (int p = 0; p < POOL_SIZE; p++) line_pool[p] = LNUM_BITS'($urandom);
    line_pool[0] = '0;
    line_pool[1] = '1;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= OP_SET;
    in_unit_index <= '0;
    in_write_value <= '0;
    in_fill_data <= '0;
    in_fill_present <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Cold miss on the top unit; a request during the fill is dropped.
    run_request(OP_GET, '1, $urandom);
    drive_item(OP_SET, '0, $urandom, $urandom, 1'b1);
    for (int w = 0; w < LINE_UNITS; w++) begin
      if (w == 0) send_fill('1, 1'b1);
      else if (w == 1) send_fill('0, 1'b1);
      else if (w == 2 || w == LINE_UNITS - 1) send_fill($urandom, 1'b0);
      else send_fill($urandom, 1'b1);
    end
    drive_item(OP_FILL, INDEX_BITS'($urandom), $urandom, $urandom, 1'b1);
    drive_item(OP_UNUSED, INDEX_BITS'($urandom), $urandom, $urandom, 1'b1);
    run_request(OP_GET, 24'hFFFFF2, $urandom);
    run_request(OP_SET, '1, '1);
    run_request(OP_GET, '1, '0);
    run_request(OP_SET, 24'hFFFFF1, MARKER);
    run_request(OP_GET, 24'hFFFFF1, $urandom);
    run_request(OP_GET, 24'hFFFFF0, $urandom);
    // Same slot, other line: the whole victim line is written back first.
    run_request(OP_SET, 24'h0000F3, 32'h12345678);
    while (awaiting_line) send_fill($urandom, 1'b1);
    run_request(OP_GET, 24'h0000F3, $urandom);
    run_request(OP_GET, '0, $urandom);
    while (awaiting_line) send_fill(pick_unit(), 1'b1);

    random_base = items_sent;
    while (items_sent - random_base < RANDOM_ITEMS || awaiting_line) begin
      gaps_on = !(items_sent - random_base >= 90 && items_sent - random_base < 180);
      r = $urandom_range(99);
      if (awaiting_line) begin
        if (r < 4) drive_item(2'($urandom_range(1)), pick_unit_index(), $urandom,
                              $urandom, 1'($urandom_range(1)));
        else send_fill(pick_unit(), $urandom_range(99) < 85);
      end else if (r < 5) begin
        drive_item(OP_FILL, INDEX_BITS'($urandom), $urandom, $urandom,
                   1'($urandom_range(1)));
      end else if (r < 9) begin
        drive_item(OP_UNUSED, INDEX_BITS'($urandom), $urandom, $urandom,
                   1'($urandom_range(1)));
      end else begin
        run_request(2'($urandom_range(1)), pick_unit_index(), pick_unit());
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d items, %0d hits, %0d misses, %0d write-back words, %0d never-set reads",
             items_sent, hit_count, miss_count, writeback_count, unset_count);
    $display("tb: %0d stray or unused-op items were dropped by the cache", ignored_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/dmuc_pkg.sv
hw/rtl/dmuc_ctrl.sv
hw/rtl/dmuc_datapath.sv
hw/rtl/direct_mapped_unit_cache.sv
test/direct_mapped_unit_cache_checker.sv
test/direct_mapped_unit_cache_tb.sv
